FILE: rtl/kcar_pkg.sv
// ----------------------------------------------------------------------------
// kcar_pkg
// Shared widths and operation codes for the key combo action resolver.
// ----------------------------------------------------------------------------
package kcar_pkg;

  // fixed field widths of the transaction ports
  localparam int KEY_IDX_W = 5;
  localparam int DATA_W    = 32;

  // operation codes carried by the opcode field
  localparam logic OP_WRITE   = 1'b0;
  localparam logic OP_RESOLVE = 1'b1;

  // reset value of the last key register
  localparam logic [KEY_IDX_W-1:0] LAST_KEY_RST = 5'd31;

endpackage

FILE: rtl/key_combo_action_resolver.sv
// ----------------------------------------------------------------------------
// key_combo_action_resolver
// Per-key action bind table with combo detection and pressed-key resolution.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall): one transaction either writes a key's
// bind word (opcode write) or resolves a pressed-key mask (opcode resolve).
// Result channel (out_valid / out_stall): exactly one result per input
// transaction, carrying the resolved action mask (zero for writes) and the
// current combo key and combo action masks.
// Configuration: cfg_we / cfg_wdata write the last key index; the combo masks
// are then rebuilt, and in_stall stays high until that finishes.
// All work goes through one read port on the bind table, one key per cycle,
// stepped by a small sequencer; in_stall is high while an item is at work.
// Write: two mask passes over keys 0..L (L = effective last key), then a
// load of the result register. Resolve: each key 0..L in turn, plus for
// each pressed combo key i a partner scan over keys i+1..L.
// The result register lets a new transaction be accepted while the previous
// result is still stalled; a finished item waits in its final state until
// the result register is free.
// Reset (rst_n, synchronous): table, combo masks cleared, last key set to 31.
// ----------------------------------------------------------------------------
module key_combo_action_resolver #(
  parameter int NUM_KEYS    = 32,
  parameter int ACTION_BITS = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // input channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_opcode,
  input  logic [kcar_pkg::KEY_IDX_W-1:0] in_key_index,
  input  logic [kcar_pkg::DATA_W-1:0]    in_bind_word,
  input  logic [kcar_pkg::DATA_W-1:0]    in_pressed_keys,
  // result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [kcar_pkg::DATA_W-1:0]    out_action_mask,
  output logic [kcar_pkg::DATA_W-1:0]    out_combo_key_bits,
  output logic [kcar_pkg::DATA_W-1:0]    out_combo_action_bits,
  // configuration
  input  logic                           cfg_we,
  input  logic [kcar_pkg::KEY_IDX_W-1:0] cfg_wdata
);
  import kcar_pkg::*;

  localparam int KW = $clog2(NUM_KEYS);
  localparam logic [KEY_IDX_W:0]   NUM_KEYS_W = (KEY_IDX_W+1)'(NUM_KEYS);
  localparam logic [KEY_IDX_W-1:0] MAX_KEY    = KEY_IDX_W'(NUM_KEYS - 1);

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_P1   = 3'd1;  // count action holders
  localparam logic [2:0] S_P2   = 3'd2;  // mark combo keys
  localparam logic [2:0] S_RI   = 3'd3;  // examine pressed key i
  localparam logic [2:0] S_RU   = 3'd4;  // scan for a partner of key i
  localparam logic [2:0] S_FIN  = 3'd5;  // load the result register

  logic [2:0]             state_r, state_nxt;
  logic [ACTION_BITS-1:0] bind_r [NUM_KEYS];
  logic [NUM_KEYS-1:0]    combo_key_r, combo_key_nxt;
  logic [ACTION_BITS-1:0] combo_act_r, combo_act_nxt;
  logic [KEY_IDX_W-1:0]   last_idx_r;
  logic [KW-1:0]          idx_r, idx_nxt;
  logic [KW-1:0]          u_r, u_nxt;
  logic [ACTION_BITS-1:0] seen1_r, seen1_nxt;
  logic [ACTION_BITS-1:0] seen2_r, seen2_nxt;
  logic [ACTION_BITS-1:0] cur_r, cur_nxt;
  logic [ACTION_BITS-1:0] res_r, res_nxt;
  logic [NUM_KEYS-1:0]    work_r, work_nxt;
  logic                   from_cfg_r, from_cfg_nxt;

  logic                   out_valid_r;
  logic [DATA_W-1:0]      out_action_r, out_key_r, out_act_r;

  logic [KW-1:0]          last_w;
  logic [KW-1:0]          rd_addr;
  logic [ACTION_BITS-1:0] rd_word;
  logic                   in_acc;
  logic                   out_free;

  // effective last key, clipped to the table
  always_comb begin
    if (last_idx_r > MAX_KEY) begin
      last_w = KW'(MAX_KEY);
    end else begin
      last_w = KW'(last_idx_r);
    end
  end

  // single table read port
  assign rd_addr = (state_r == S_RU) ? u_r : idx_r;
  assign rd_word = bind_r[rd_addr];

  assign in_stall = (state_r != S_IDLE) || cfg_we;
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    combo_key_nxt = combo_key_r;
    combo_act_nxt = combo_act_r;
    idx_nxt       = idx_r;
    u_nxt         = u_r;
    seen1_nxt     = seen1_r;
    seen2_nxt     = seen2_r;
    cur_nxt       = cur_r;
    res_nxt       = res_r;
    work_nxt      = work_r;
    from_cfg_nxt  = from_cfg_r;
    unique case (state_r)
      S_IDLE: begin
        idx_nxt   = '0;
        seen1_nxt = '0;
        seen2_nxt = '0;
        res_nxt   = '0;
        if (cfg_we) begin
          from_cfg_nxt = 1'b1;
          state_nxt    = S_P1;
        end else if (in_valid) begin
          from_cfg_nxt = 1'b0;
          work_nxt     = in_pressed_keys[NUM_KEYS-1:0];
          state_nxt    = (in_opcode == OP_RESOLVE) ? S_RI : S_P1;
        end
      end
      S_P1: begin
        seen2_nxt = seen2_r | (seen1_r & rd_word);
        seen1_nxt = seen1_r | rd_word;
        if (idx_r == last_w) begin
          combo_act_nxt = seen2_nxt;
          combo_key_nxt = '0;
          idx_nxt       = '0;
          state_nxt     = S_P2;
        end else begin
          idx_nxt = KW'(idx_r + 1'b1);
        end
      end
      S_P2: begin
        combo_key_nxt[idx_r] = |(rd_word & combo_act_r);
        if (idx_r == last_w) begin
          state_nxt = from_cfg_r ? S_IDLE : S_FIN;
        end else begin
          idx_nxt = KW'(idx_r + 1'b1);
        end
      end
      S_RI: begin
        if (work_r[idx_r] && (rd_word != '0)) begin
          if (!combo_key_r[idx_r]) begin
            res_nxt = res_r | rd_word;
          end else if (((rd_word & combo_act_r) == '0) || (idx_r == last_w)) begin
            res_nxt = res_r | (rd_word & ~combo_act_r);
          end else begin
            cur_nxt = rd_word;
            u_nxt   = KW'(idx_r + 1'b1);
          end
        end
        if (work_r[idx_r] && (rd_word != '0) && combo_key_r[idx_r]
            && ((rd_word & combo_act_r) != '0) && (idx_r != last_w)) begin
          state_nxt = S_RU;
        end else if (idx_r == last_w) begin
          state_nxt = S_FIN;
        end else begin
          idx_nxt = KW'(idx_r + 1'b1);
        end
      end
      S_RU: begin
        if (work_r[u_r] && ((rd_word & cur_r & combo_act_r) != '0)) begin
          // partner found: add shared combo actions, drop both keys
          res_nxt          = res_r | (rd_word & cur_r & combo_act_r);
          work_nxt[idx_r]  = 1'b0;
          work_nxt[u_r]    = 1'b0;
          state_nxt        = (idx_r == last_w) ? S_FIN : S_RI;
          idx_nxt          = (idx_r == last_w) ? idx_r : KW'(idx_r + 1'b1);
        end else if (u_r == last_w) begin
          // no partner: only the non-combo actions count
          res_nxt   = res_r | (cur_r & ~combo_act_r);
          state_nxt = (idx_r == last_w) ? S_FIN : S_RI;
          idx_nxt   = (idx_r == last_w) ? idx_r : KW'(idx_r + 1'b1);
        end else begin
          u_nxt = KW'(u_r + 1'b1);
        end
      end
      S_FIN: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      combo_key_r <= '0;
      combo_act_r <= '0;
      last_idx_r  <= LAST_KEY_RST;
      out_valid_r <= 1'b0;
      from_cfg_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      combo_key_r <= combo_key_nxt;
      combo_act_r <= combo_act_nxt;
      from_cfg_r  <= from_cfg_nxt;
      if (cfg_we) begin
        last_idx_r <= cfg_wdata;
      end
      if ((state_r == S_FIN) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // bind table, cleared at reset, written on an accepted write transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_KEYS; k++) begin
        bind_r[k] <= '0;
      end
    end else if (in_acc && (in_opcode == OP_WRITE)
                 && ({1'b0, in_key_index} < NUM_KEYS_W)) begin
      bind_r[KW'(in_key_index)] <= in_bind_word[ACTION_BITS-1:0];
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    idx_r   <= idx_nxt;
    u_r     <= u_nxt;
    seen1_r <= seen1_nxt;
    seen2_r <= seen2_nxt;
    cur_r   <= cur_nxt;
    res_r   <= res_nxt;
    work_r  <= work_nxt;
  end

  // result register
  always_ff @(posedge clk) begin
    if ((state_r == S_FIN) && out_free) begin
      out_action_r <= DATA_W'(res_r);
      out_key_r    <= DATA_W'(combo_key_r);
      out_act_r    <= DATA_W'(combo_act_r);
    end
  end

  assign out_valid             = out_valid_r;
  assign out_action_mask       = out_action_r;
  assign out_combo_key_bits    = out_key_r;
  assign out_combo_action_bits = out_act_r;

endmodule

FILE: test/tb_key_combo_action_resolver.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_key_combo_action_resolver
// Self-checking bench for the key combo action resolver. A directed table
// covers reset state, pairing at the last key, lone combo keys, full-width
// bind words and last-key limits, followed by randomized phases with small
// action pools so that combos form often. An in-bench predictor tracks the
// bind table and combo masks; every result is compared field by field, with
// random idle cycles on the input side and random stalls on the result side.
// ----------------------------------------------------------------------------
module tb_key_combo_action_resolver;
  import kcar_pkg::*;

  localparam int ITEM_TARGET  = 1550;
  localparam int CYCLE_LIMIT  = 4_000_000;
  localparam int DRAIN_CYCLES = 600;
  localparam int MAX_REPORTS  = 40;

  typedef struct packed {
    logic                 opcode;
    logic [KEY_IDX_W-1:0] key_index;
    logic [DATA_W-1:0]    bind_word;
    logic [DATA_W-1:0]    pressed_keys;
  } key_item_t;

  typedef struct packed {
    logic [DATA_W-1:0] action_mask;
    logic [DATA_W-1:0] combo_key_bits;
    logic [DATA_W-1:0] combo_action_bits;
  } resolver_result_t;

  // checked: result from the predictor; typed: result written in the row
  typedef enum logic [1:0] {ROW_CHECKED, ROW_TYPED, ROW_LAST_KEY} row_kind_e;

  typedef struct packed {
    row_kind_e            kind;
    key_item_t            item;
    resolver_result_t     res;
    logic [KEY_IDX_W-1:0] last_val;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic in_opcode;
  logic [KEY_IDX_W-1:0] in_key_index;
  logic [DATA_W-1:0] in_bind_word;
  logic [DATA_W-1:0] in_pressed_keys;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [DATA_W-1:0] out_action_mask;
  logic [DATA_W-1:0] out_combo_key_bits;
  logic [DATA_W-1:0] out_combo_action_bits;
  logic cfg_we;
  logic [KEY_IDX_W-1:0] cfg_wdata;

  // predictor state
  logic [DATA_W-1:0] bind_tbl [32];
  logic [DATA_W-1:0] exp_key_mask;
  logic [DATA_W-1:0] exp_act_mask;
  logic [KEY_IDX_W-1:0] exp_last;

  resolver_result_t pending_results[$];
  stim_row_t directed_rows[$];

  int mismatches = 0;
  int n_writes = 0;
  int n_resolves = 0;
  int n_last_cfg = 0;
  int n_checked = 0;
  int cycle_count = 0;
  int gap_due = 0;
  int stall_left = 0;
  bit calm_phase = 1'b0;

  key_combo_action_resolver dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_opcode             (in_opcode),
    .in_key_index          (in_key_index),
    .in_bind_word          (in_bind_word),
    .in_pressed_keys       (in_pressed_keys),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_action_mask       (out_action_mask),
    .out_combo_key_bits    (out_combo_key_bits),
    .out_combo_action_bits (out_combo_action_bits),
    .cfg_we                (cfg_we),
    .cfg_wdata             (cfg_wdata)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_results.size());
      $display("tb_key_combo_action_resolver NOT OK");
      $finish;
    end
  end

  // actions held by two or more keys up to the last key, and their holders
  function automatic void rebuild_combo_masks();
    logic [DATA_W-1:0] holders;
    int cnt;
    exp_key_mask = '0;
    exp_act_mask = '0;
    for (int a = 0; a < DATA_W; a++) begin
      holders = '0;
      cnt = 0;
      for (int k = 0; k <= int'(exp_last); k++) begin
        if (bind_tbl[k][a]) begin
          cnt++;
          holders[k] = 1'b1;
        end
      end
      if (cnt > 1) begin
        exp_key_mask |= holders;
        exp_act_mask[a] = 1'b1;
      end
    end
  endfunction

  // walk pressed keys in order, pairing combo keys with a later partner
  function automatic logic [DATA_W-1:0] resolve_pressed(logic [DATA_W-1:0] pressed);
    logic [DATA_W-1:0] held;
    logic [DATA_W-1:0] acts;
    logic [DATA_W-1:0] shared;
    logic [DATA_W-1:0] res;
    bit paired;
    held = pressed;
    res = '0;
    for (int i = 0; i <= int'(exp_last); i++) begin
      acts = bind_tbl[i];
      if (held[i] && acts != '0) begin
        if (!exp_key_mask[i]) begin
          res |= acts;
        end else begin
          shared = acts & exp_act_mask;
          paired = 1'b0;
          for (int u = i + 1; u <= int'(exp_last) && !paired; u++) begin
            if (held[u] && (bind_tbl[u] & shared) != '0) begin
              res |= shared & bind_tbl[u];
              held[i] = 1'b0;
              held[u] = 1'b0;
              paired = 1'b1;
            end
          end
          if (!paired) res |= acts & ~exp_act_mask;
        end
      end
    end
    return res;
  endfunction

  function automatic void add_row(row_kind_e kind, logic op, logic [KEY_IDX_W-1:0] key,
                                  logic [DATA_W-1:0] word, logic [DATA_W-1:0] pressed,
                                  logic [DATA_W-1:0] act, logic [DATA_W-1:0] ckeys,
                                  logic [DATA_W-1:0] cacts, logic [KEY_IDX_W-1:0] last_val);
    stim_row_t row;
    row.kind = kind;
    row.item = '{op, key, word, pressed};
    row.res = '{act, ckeys, cacts};
    row.last_val = last_val;
    directed_rows.push_back(row);
  endfunction

  function automatic void check_field(string fname, logic [DATA_W-1:0] want_v,
                                      logic [DATA_W-1:0] got_v);
    if (got_v !== want_v) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %h, actual %h", $time, fname, want_v, got_v);
    end
  endfunction

  // present one transaction, wait for acceptance, record its expected result
  task automatic put_item(input key_item_t it, input bit more, input bit typed,
                          input resolver_result_t typed_res);
    resolver_result_t r;
    repeat (gap_due) @(posedge clk);
    in_valid        <= 1'b1;
    in_opcode       <= it.opcode;
    in_key_index    <= it.key_index;
    in_bind_word    <= it.bind_word;
    in_pressed_keys <= it.pressed_keys;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    if (it.opcode == OP_WRITE) begin
      bind_tbl[it.key_index] = it.bind_word;
      rebuild_combo_masks();
      r.action_mask = '0;
      n_writes++;
    end else begin
      r.action_mask = resolve_pressed(it.pressed_keys);
      n_resolves++;
    end
    r.combo_key_bits = exp_key_mask;
    r.combo_action_bits = exp_act_mask;
    pending_results.push_back(typed ? typed_res : r);
    // keep valid high only when the next transaction follows at once
    gap_due = calm_phase ? 0 : $urandom_range(0, 7);
    if (!more || gap_due != 0) in_valid <= 1'b0;
  endtask

  // last key register write, only with nothing in flight
  task automatic write_last_idx(input logic [KEY_IDX_W-1:0] val);
    while (pending_results.size() != 0) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    exp_last = val;
    rebuild_combo_masks();
    n_last_cfg++;
  endtask

  // result side: random stall after each transaction, check against oldest
  always @(posedge clk) begin
    resolver_result_t want;
    if (rst_n !== 1'b1) begin
      stall_left = 0;
    end else if (out_valid === 1'b1 && !out_stall) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: unexpected result, expected none, actual %h %h %h", $time,
                   out_action_mask, out_combo_key_bits, out_combo_action_bits);
      end else begin
        want = pending_results.pop_front();
        check_field("action_mask", want.action_mask, out_action_mask);
        check_field("combo_key_bits", want.combo_key_bits, out_combo_key_bits);
        check_field("combo_action_bits", want.combo_action_bits, out_combo_action_bits);
        n_checked++;
      end
      stall_left = calm_phase ? 0 : $urandom_range(0, 7);
    end else if (stall_left != 0) begin
      stall_left--;
    end
    out_stall <= (stall_left != 0);
  end

  initial begin
    key_item_t it;
    stim_row_t row;
    bit more;
    int phase_len;
    logic [KEY_IDX_W-1:0] phase_last;
    int act_base;

    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_opcode       <= OP_WRITE;
    in_key_index    <= '0;
    in_bind_word    <= '0;
    in_pressed_keys <= '0;
    cfg_we          <= 1'b0;
    cfg_wdata       <= '0;

    for (int k = 0; k < 32; k++) bind_tbl[k] = '0;
    exp_last = LAST_KEY_RST;
    rebuild_combo_masks();

    // directed table
    add_row(ROW_TYPED, OP_RESOLVE, 5'd0, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 5'd0);
    add_row(ROW_TYPED, OP_WRITE, 5'd0, 32'h0000_0001, 32'h0, 32'h0, 32'h0, 32'h0, 5'd0);
    add_row(ROW_TYPED, OP_WRITE, 5'd31, 32'h0000_0001, 32'h0,
            32'h0, 32'h8000_0001, 32'h0000_0001, 5'd0);
    // partner found at the last key
    add_row(ROW_TYPED, OP_RESOLVE, 5'd0, 32'h0, 32'h8000_0001,
            32'h0000_0001, 32'h8000_0001, 32'h0000_0001, 5'd0);
    // lone combo key adds nothing but non-combo actions
    add_row(ROW_TYPED, OP_RESOLVE, 5'd0, 32'h0, 32'h0000_0001,
            32'h0, 32'h8000_0001, 32'h0000_0001, 5'd0);
    add_row(ROW_TYPED, OP_WRITE, 5'd5, 32'hFFFF_FFFF, 32'h0,
            32'h0, 32'h8000_0021, 32'h0000_0001, 5'd0);
    add_row(ROW_TYPED, OP_RESOLVE, 5'd0, 32'h0, 32'h0000_0020,
            32'hFFFF_FFFE, 32'h8000_0021, 32'h0000_0001, 5'd0);
    add_row(ROW_TYPED, OP_RESOLVE, 5'd0, 32'h0, 32'h0000_0021,
            32'h0000_0001, 32'h8000_0021, 32'h0000_0001, 5'd0);
    add_row(ROW_TYPED, OP_RESOLVE, 5'd0, 32'h0, 32'h8000_0020,
            32'h0000_0001, 32'h8000_0021, 32'h0000_0001, 5'd0);
    // first pair consumes key 5, key 31 is left alone
    add_row(ROW_TYPED, OP_RESOLVE, 5'd0, 32'h0, 32'h8000_0021,
            32'h0000_0001, 32'h8000_0021, 32'h0000_0001, 5'd0);
    add_row(ROW_CHECKED, OP_WRITE, 5'd12, 32'hA5A5_A5A5, 32'h0, 32'h0, 32'h0, 32'h0, 5'd0);
    add_row(ROW_CHECKED, OP_WRITE, 5'd20, 32'h5A5A_5A5A, 32'h0, 32'h0, 32'h0, 32'h0, 5'd0);
    add_row(ROW_CHECKED, OP_RESOLVE, 5'd0, 32'h0, 32'h0010_1020, 32'h0, 32'h0, 32'h0, 5'd0);
    add_row(ROW_CHECKED, OP_RESOLVE, 5'd0, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 5'd0);
    add_row(ROW_CHECKED, OP_WRITE, 5'd31, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 5'd0);
    // pressed bits above a low last key are ignored
    add_row(ROW_LAST_KEY, OP_WRITE, 5'd0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 5'd4);
    add_row(ROW_CHECKED, OP_RESOLVE, 5'd0, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 5'd0);
    add_row(ROW_CHECKED, OP_WRITE, 5'd3, 32'h0000_0100, 32'h0, 32'h0, 32'h0, 32'h0, 5'd0);
    add_row(ROW_LAST_KEY, OP_WRITE, 5'd0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 5'd0);
    add_row(ROW_CHECKED, OP_RESOLVE, 5'd0, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 5'd0);
    add_row(ROW_CHECKED, OP_WRITE, 5'd31, 32'h8000_0000, 32'h0, 32'h0, 32'h0, 32'h0, 5'd0);
    add_row(ROW_LAST_KEY, OP_WRITE, 5'd0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 5'd31);
    add_row(ROW_CHECKED, OP_RESOLVE, 5'd0, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 5'd0);
    add_row(ROW_CHECKED, OP_RESOLVE, 5'd0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 5'd0);
    add_row(ROW_CHECKED, OP_WRITE, 5'd0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 5'd0);

    // reset
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // walk the directed table
    for (int idx = 0; idx < directed_rows.size(); idx++) begin
      row = directed_rows[idx];
      if (row.kind == ROW_LAST_KEY) begin
        write_last_idx(row.last_val);
      end else begin
        more = (idx + 1 < directed_rows.size()) && (directed_rows[idx + 1].kind != ROW_LAST_KEY);
        put_item(row.item, more, row.kind == ROW_TYPED, row.res);
      end
    end

    // random phases, each with its own last key and action pool
    while (n_writes + n_resolves < ITEM_TARGET) begin
      case ($urandom_range(0, 5))
        0:       phase_last = 5'd0;
        1:       phase_last = 5'd31;
        default: phase_last = KEY_IDX_W'($urandom_range(0, 31));
      endcase
      write_last_idx(phase_last);
      calm_phase = ($urandom_range(0, 3) == 0);
      act_base = $urandom_range(0, 24);
      phase_len = $urandom_range(40, 120);
      if (phase_len > ITEM_TARGET - (n_writes + n_resolves))
        phase_len = ITEM_TARGET - (n_writes + n_resolves);
      for (int j = 0; j < phase_len; j++) begin
        it.opcode = ($urandom_range(0, 9) < 4) ? OP_WRITE : OP_RESOLVE;
        it.key_index = KEY_IDX_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 31)
                                                              : $urandom_range(0, phase_last));
        // bind words: mostly a few bits from a narrow pool so combos form
        case ($urandom_range(0, 9))
          0:       it.bind_word = '0;
          1:       it.bind_word = '1;
          2, 3:    it.bind_word = $urandom;
          default: it.bind_word = ((32'd1 << $urandom_range(0, 7)) |
                                   ($urandom & $urandom & 32'hFF)) << act_base;
        endcase
        // pressed masks: half the time a handful of keys within range
        case ($urandom_range(0, 9))
          0:       it.pressed_keys = '1;
          1:       it.pressed_keys = $urandom & $urandom;
          2, 3, 4: it.pressed_keys = $urandom;
          default: begin
            it.pressed_keys = '0;
            repeat ($urandom_range(2, 4)) it.pressed_keys[$urandom_range(0, phase_last)] = 1'b1;
          end
        endcase
        put_item(it, j < phase_len - 1, 1'b0, '0);
      end
    end

    // drain
    while (pending_results.size() != 0) @(posedge clk);
    calm_phase = 1'b1;
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d bind writes and %0d resolves over %0d last-key settings",
             n_writes, n_resolves, n_last_cfg);
    $display("%0d results compared, %0d mismatches", n_checked, mismatches);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("tb_key_combo_action_resolver OK");
    end else begin
      $display("tb_key_combo_action_resolver NOT OK");
    end
    $finish;
  end

endmodule

FILE: key_combo_action_resolver.f
rtl/kcar_pkg.sv
rtl/key_combo_action_resolver.sv
test/tb_key_combo_action_resolver.sv
